// ===== hw/rtl/rgba_abd_pkg.sv =====
// Shared constants, types and the reciprocal table of the RGBA8 box downsampler.
package rgba_abd_pkg;

  // Largest supported source width; sets the line store depth.
  localparam int MaxSrcWidth  = 16384;
  localparam int MaxSrcHeight = 16384;

  localparam int AxisW     = 15;
  localparam int PosW      = $clog2(MaxSrcWidth);
  localparam int RowW      = $clog2(MaxSrcHeight);
  localparam int LineDepth = MaxSrcWidth / 2;
  localparam int LineAddrW = (LineDepth > 1) ? $clog2(LineDepth) : 1;
  localparam int TIdxW     = LineAddrW;
  localparam int TRowW     = $clog2(MaxSrcHeight / 2);

  localparam int ChanW    = 8;
  localparam int LaneW    = 12;  // holds 9 * 255
  localparam int NumLanes = 4;
  localparam int CntW     = 4;   // box sample count, 1..9

  // Division by the sample count: multiply by ceil(2^16 / count), exact for
  // dividends below 2^13.
  localparam int RecipShift = 16;
  localparam int RecipW     = RecipShift + 1;
  localparam int ProdW      = RecipShift + ChanW;

  localparam logic [RecipW-1:0] Recip1 = RecipW'(1 << RecipShift);
  localparam logic [RecipW-1:0] Recip2 = RecipW'((1 << RecipShift) / 2);
  localparam logic [RecipW-1:0] Recip3 = RecipW'((1 << RecipShift) / 3 + 1);
  localparam logic [RecipW-1:0] Recip4 = RecipW'((1 << RecipShift) / 4);
  localparam logic [RecipW-1:0] Recip6 = RecipW'((1 << RecipShift) / 6 + 1);
  localparam logic [RecipW-1:0] Recip9 = RecipW'((1 << RecipShift) / 9 + 1);

  typedef logic [LaneW-1:0]                lane_sum_t;
  typedef logic [NumLanes-1:0][LaneW-1:0]  box_sum_t;   // red in lane 0
  typedef logic [NumLanes-1:0][ChanW-1:0]  texel_t;

  typedef enum logic [0:0] {
    CFG_SRC_WIDTH  = 1'b0,
    CFG_SRC_HEIGHT = 1'b1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_MERGE = 2'd1,
    ST_DIV   = 2'd2
  } state_e;

  typedef struct packed {
    logic                 wr_en;
    logic [LineAddrW-1:0] wr_addr;
    logic                 rd_en;
    logic [LineAddrW-1:0] rd_addr;
  } line_req_t;

  function automatic logic [RecipW-1:0] recip(input logic [CntW-1:0] cnt);
    logic [RecipW-1:0] r;
    unique case (cnt)
      4'd2:    r = Recip2;
      4'd3:    r = Recip3;
      4'd4:    r = Recip4;
      4'd6:    r = Recip6;
      4'd9:    r = Recip9;
      default: r = Recip1;
    endcase
    return r;
  endfunction

endpackage

// ===== hw/rtl/rgba_abd_src_if.sv =====
// Source texel channel: valid/ready handshake with one RGBA8 texel.
interface rgba_abd_src_if;
  import rgba_abd_pkg::*;

  logic             valid;
  logic             ready;
  logic [ChanW-1:0] in_red;
  logic [ChanW-1:0] in_green;
  logic [ChanW-1:0] in_blue;
  logic [ChanW-1:0] in_alpha;

  modport source (output valid, in_red, in_green, in_blue, in_alpha, input ready);
  modport sink   (input valid, in_red, in_green, in_blue, in_alpha, output ready);
endinterface

// ===== hw/rtl/rgba_abd_dst_if.sv =====
// Target texel channel: valid/ready handshake with one averaged RGBA8 texel.
interface rgba_abd_dst_if;
  import rgba_abd_pkg::*;

  logic             valid;
  logic             ready;
  logic [ChanW-1:0] out_red;
  logic [ChanW-1:0] out_green;
  logic [ChanW-1:0] out_blue;
  logic [ChanW-1:0] out_alpha;
  logic             last_texel;

  modport source (output valid, out_red, out_green, out_blue, out_alpha, last_texel,
                  input ready);
  modport sink   (input valid, out_red, out_green, out_blue, out_alpha, last_texel,
                  output ready);
endinterface

// ===== hw/rtl/rgba_abd_line_store.sv =====
// Line store of per-column partial box sums, one write and one registered read port.
module rgba_abd_line_store (
  input  logic                    clk_i,
  input  rgba_abd_pkg::line_req_t req_i,
  input  rgba_abd_pkg::box_sum_t  wr_data_i,
  output rgba_abd_pkg::box_sum_t  rd_data_o
);
  import rgba_abd_pkg::*;

  box_sum_t mem_q [LineDepth];
  box_sum_t rd_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[req_i.wr_addr] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.rd_en) begin
      rd_q <= mem_q[req_i.rd_addr];
    end
  end

  assign rd_data_o = rd_q;

endmodule

// ===== hw/rtl/rgba_abd_lane.sv =====
// One channel lane: rounded division of a box sum by the sample count.
module rgba_abd_lane (
  input  logic                                clk_i,
  input  logic                                en_i,
  input  rgba_abd_pkg::lane_sum_t             sum_i,
  input  logic [rgba_abd_pkg::CntW-1:0]       cnt_i,
  output logic [rgba_abd_pkg::ChanW-1:0]      avg_o
);
  import rgba_abd_pkg::*;

  logic [LaneW:0]   dividend;
  logic [ProdW-1:0] prod_d;
  logic [ProdW-1:0] prod_q;

  // (sum + count/2) * ceil(2^16/count), keep the bits that give the byte
  always_comb begin
    dividend = {1'b0, sum_i} + (LaneW + 1)'(cnt_i >> 1);
    prod_d   = ProdW'(dividend) * ProdW'(recip(cnt_i));
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
    end
  end

  assign avg_o = prod_q[ProdW-1:RecipShift];

endmodule

// ===== hw/rtl/rgba8_area_box_downsample_core.sv =====
// Top level of the RGBA8 area-box mip downsampler: position tracking, lanes, output register.
//
//  channel | dir | handshake         | payload
//  --------+-----+-------------------+----------------------------------------------
//  in_if   | in  | valid / ready     | in_red, in_green, in_blue, in_alpha
//  out_if  | out | valid / ready     | out_red, out_green, out_blue, out_alpha, last_texel
//  cfg     | in  | cfg_we_i (no wait)| cfg_idx_i, cfg_data_i
//
// Sequence: a texel that does not close a box row span is taken in ST_IDLE alone;
// one that closes a span also passes ST_MERGE (registered line store read, then
// merge and write back); one that completes a box passes the line store read and
// the lane multiplier register, then waits in ST_DIV while the output register is occupied.
// Reset: positions and row sum clear, both sizes read as 1; the line store is
// not cleared, since the first row of each band writes an entry before any read.
// Stalls: a finished texel waits in the output register while the next source
// transaction is accepted; only the final lane load waits for the register.
module rgba8_area_box_downsample_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  rgba_abd_pkg::cfg_idx_e         cfg_idx_i,
  input  logic [rgba_abd_pkg::AxisW-1:0] cfg_data_i,
  rgba_abd_src_if.sink                   in_if,
  rgba_abd_dst_if.source                 out_if
);
  import rgba_abd_pkg::*;

  state_e state_q, state_d;

  // Level geometry, precomputed when a size register is written
  logic [PosW-1:0]  sw_last_q;
  logic [RowW-1:0]  sh_last_q;
  logic [TIdxW-1:0] tw_last_q;
  logic [TRowW-1:0] th_last_q;
  logic             odd_w_q, odd_h_q;
  logic             one_w_q, one_h_q;
  logic [AxisW-1:0] w_clamp, h_clamp;

  // Scan position and running box sum of the current row span
  logic [PosW-1:0]  col_q, col_d;
  logic [RowW-1:0]  row_q, row_d;
  box_sum_t         row_sum_q, row_sum_d;

  // Box closing in flight
  box_sum_t         pend_sum_q;
  logic             pend_first_q, pend_end_q, pend_last_q;
  logic [TIdxW-1:0] pend_idx_q;
  logic [CntW-1:0]  pend_cnt_q;

  logic                           out_valid_q;
  logic [NumLanes-1:0][ChanW-1:0] out_chan_q;
  logic                           out_last_q;

  logic             in_fire, out_fire;
  logic [PosW-1:0]  cx;
  logic [RowW-1:0]  ry;
  logic [TIdxW-1:0] tx, tx_raw;
  logic [TRowW-1:0] ty, ty_raw;
  logic             x_end, y_first, y_end, box_last;
  logic [1:0]       wx, wy;
  logic [CntW-1:0]  cnt;
  texel_t           texel;
  box_sum_t         sum_nxt, merged, line_rd;
  line_req_t        line_req;
  logic             lane_en, out_load;
  logic [NumLanes-1:0][ChanW-1:0] lane_avg;

  assign in_fire     = in_if.valid && in_if.ready;
  assign out_fire    = out_if.valid && out_if.ready;
  assign in_if.ready = (state_q == ST_IDLE);

  // Sizes clamp to 1..max
  always_comb begin
    w_clamp = cfg_data_i;
    if (cfg_data_i == '0) begin
      w_clamp = AxisW'(1);
    end else if (cfg_data_i > AxisW'(MaxSrcWidth)) begin
      w_clamp = AxisW'(MaxSrcWidth);
    end
    h_clamp = cfg_data_i;
    if (cfg_data_i == '0) begin
      h_clamp = AxisW'(1);
    end else if (cfg_data_i > AxisW'(MaxSrcHeight)) begin
      h_clamp = AxisW'(MaxSrcHeight);
    end
  end

  // Where the incoming texel falls: target index, box edges, box size
  always_comb begin
    cx     = (col_q > sw_last_q) ? '0 : col_q;
    ry     = (row_q > sh_last_q) ? '0 : row_q;
    tx_raw = TIdxW'(cx >> 1);
    ty_raw = TRowW'(ry >> 1);
    tx     = (tx_raw > tw_last_q) ? tw_last_q : tx_raw;
    ty     = (ty_raw > th_last_q) ? th_last_q : ty_raw;

    x_end   = (cx == sw_last_q) || (cx[0] && (tx < tw_last_q));
    y_first = (ry == RowW'({ty, 1'b0}));
    y_end   = (ry == sh_last_q) || (ry[0] && (ty < th_last_q));
    box_last = (tx == tw_last_q) && (ty == th_last_q);

    // The last box of an odd axis is 3 wide, an axis of one texel gives 1
    wx  = one_w_q ? 2'd1 : ((tx == tw_last_q) && odd_w_q) ? 2'd3 : 2'd2;
    wy  = one_h_q ? 2'd1 : ((ty == th_last_q) && odd_h_q) ? 2'd3 : 2'd2;
    cnt = CntW'(CntW'(wx) * CntW'(wy));

    if (cx == sw_last_q) begin
      col_d = '0;
      row_d = (ry == sh_last_q) ? '0 : ry + RowW'(1);
    end else begin
      col_d = cx + PosW'(1);
      row_d = ry;
    end
  end

  // Lane adds never carry into the next lane
  assign texel = {in_if.in_alpha, in_if.in_blue, in_if.in_green, in_if.in_red};

  always_comb begin
    for (int l = 0; l < NumLanes; l++) begin
      sum_nxt[l] = row_sum_q[l] + LaneW'(texel[l]);
      merged[l]  = pend_first_q ? pend_sum_q[l] : line_rd[l] + pend_sum_q[l];
    end
    row_sum_d = x_end ? '0 : sum_nxt;
  end

  // Sequencer: accept, merge with the line store, divide and hand off
  always_comb begin
    state_d          = state_q;
    line_req.wr_en   = 1'b0;
    line_req.wr_addr = pend_idx_q;
    line_req.rd_en   = 1'b0;
    line_req.rd_addr = tx;
    lane_en          = 1'b0;
    out_load         = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire && x_end) begin
          line_req.rd_en = !y_first;
          state_d        = ST_MERGE;
        end
      end
      ST_MERGE: begin
        if (pend_end_q) begin
          lane_en = 1'b1;
          state_d = ST_DIV;
        end else begin
          line_req.wr_en = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      ST_DIV: begin
        if (!out_valid_q || out_if.ready) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Geometry, position and row sum; a size write restarts the level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sw_last_q <= '0;
      sh_last_q <= '0;
      tw_last_q <= '0;
      th_last_q <= '0;
      odd_w_q   <= 1'b1;
      odd_h_q   <= 1'b1;
      one_w_q   <= 1'b1;
      one_h_q   <= 1'b1;
      col_q     <= '0;
      row_q     <= '0;
      row_sum_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_SRC_WIDTH: begin
          sw_last_q <= PosW'(w_clamp - AxisW'(1));
          tw_last_q <= (w_clamp > AxisW'(1)) ? TIdxW'((w_clamp >> 1) - AxisW'(1)) : '0;
          odd_w_q   <= w_clamp[0];
          one_w_q   <= (w_clamp == AxisW'(1));
        end
        CFG_SRC_HEIGHT: begin
          sh_last_q <= RowW'(h_clamp - AxisW'(1));
          th_last_q <= (h_clamp > AxisW'(1)) ? TRowW'((h_clamp >> 1) - AxisW'(1)) : '0;
          odd_h_q   <= h_clamp[0];
          one_h_q   <= (h_clamp == AxisW'(1));
        end
      endcase
      col_q     <= '0;
      row_q     <= '0;
      row_sum_q <= '0;
    end else if (in_fire) begin
      col_q     <= col_d;
      row_q     <= row_d;
      row_sum_q <= row_sum_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && x_end) begin
      pend_sum_q   <= sum_nxt;
      pend_first_q <= y_first;
      pend_end_q   <= y_end;
      pend_last_q  <= box_last;
      pend_idx_q   <= tx;
      pend_cnt_q   <= cnt;
    end
  end

  rgba_abd_line_store u_line_store (
    .clk_i     (clk_i),
    .req_i     (line_req),
    .wr_data_i (merged),
    .rd_data_o (line_rd)
  );

  for (genvar l = 0; l < NumLanes; l++) begin : g_lane
    rgba_abd_lane u_lane (
      .clk_i (clk_i),
      .en_i  (lane_en),
      .sum_i (merged[l]),
      .cnt_i (pend_cnt_q),
      .avg_o (lane_avg[l])
    );
  end

  // Merge the lanes into the output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_fire) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_chan_q <= lane_avg;
      out_last_q <= pend_last_q;
    end
  end

  assign out_if.valid      = out_valid_q;
  assign out_if.out_red    = out_chan_q[0];
  assign out_if.out_green  = out_chan_q[1];
  assign out_if.out_blue   = out_chan_q[2];
  assign out_if.out_alpha  = out_chan_q[3];
  assign out_if.last_texel = out_last_q;

  // Scan position stays inside the configured level
  a_pos_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (col_q <= sw_last_q) && (row_q <= sh_last_q))
    else $error("scan position outside level");

  // A texel that closes a row span always goes on to the merge step
  a_span_merge: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && x_end) |=> (state_q == ST_MERGE))
    else $error("closed span did not reach merge");

  // A completed box is loaded into the lanes and then the divide step
  a_box_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MERGE && pend_end_q) |=> (state_q == ST_DIV))
    else $error("completed box skipped divide");

  // The divide step hands its result off as soon as the register is free
  a_div_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV && (!out_valid_q || out_if.ready)) |=> out_valid_q)
    else $error("result not loaded into output register");

endmodule
